>>> sv/igemm_pkg.sv
// ============================================================================
// igemm_pkg: shared types and constants of the int8 dense layer
// Operation codes, register map, saturation limits and the bundles that
// travel between the top level and the multiply unit.
// ============================================================================
package igemm_pkg;

    // Most results one row may produce.
    localparam int RESULT_CAP = 8;

    // Operation carried by an input word.
    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_TABLE  = 2'd2,
        OP_ACT    = 2'd3
    } op_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_DEPTH = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;

    // Register reset values.
    localparam logic [3:0]  COLS_RESET  = 4'd8;
    localparam logic [7:0]  DEPTH_RESET = 8'd128;
    localparam logic [15:0] ROWS_RESET  = 16'd8;

    // Saturation limits of the biased sum and the table offset.
    localparam logic signed [32:0] SAT_MAX      = 33'sd127;
    localparam logic signed [32:0] SAT_MIN      = -33'sd128;
    localparam logic [7:0]         TABLE_OFFSET = 8'd128;

    // Four bytes of one activation group or one weight group.
    typedef logic [3:0][7:0] byte4_t;

    // Control of one pass through the multiply unit.
    typedef struct packed {
        logic       valid;
        logic [3:0] lane_en;
    } mac_ctrl_t;

    // Result of the multiply unit.
    typedef struct packed {
        logic               valid;
        logic signed [17:0] sum;
    } mac_out_t;

endpackage

>>> sv/igemm_ram.sv
// ============================================================================
// igemm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module igemm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/igemm_mac.sv
// ============================================================================
// igemm_mac: four-lane signed byte multiply unit
// Multiplies four activation bytes by four weight bytes, drops the lanes
// that lie past the reduction depth and registers the sum.
// ============================================================================
module igemm_mac (
    input  logic                  clk,
    input  logic                  rst_n,
    input  igemm_pkg::mac_ctrl_t  ctrl,
    input  igemm_pkg::byte4_t     act,
    input  igemm_pkg::byte4_t     wt,
    output igemm_pkg::mac_out_t   result
);
    import igemm_pkg::*;

    logic signed [15:0] prod [4];
    logic signed [17:0] dot;
    logic               valid_reg;
    logic               valid_next;
    logic signed [17:0] sum_reg;

    // One signed product per lane.
    for (genvar gi = 0; gi < 4; gi++)
    begin : g_lane
        assign prod[gi] = $signed(act[gi]) * $signed(wt[gi]);
    end

    // Sum of the enabled lanes; a disabled lane counts as zero.
    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (ctrl.lane_en[i])
            begin
                dot = dot + 18'(prod[i]);
            end
        end
    end

    assign valid_next = ctrl.valid;

    // Valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Sum register.
    always_ff @(posedge clk)
    begin
        sum_reg <= dot;
    end

    assign result.valid = valid_reg;
    assign result.sum   = sum_reg;

endmodule

>>> sv/int8_gemm_bias_sat_lut.sv
// ============================================================================
// int8_gemm_bias_sat_lut: int8 dense layer with a table-lookup activation
// Loads weights, biases and a 256-entry table, accumulates activation
// groups column by column and emits one looked-up result per column.
// ============================================================================
// A load word (weight, bias or table entry) completes with busy staying
// low. An activation group keeps busy high while one four-lane multiply
// unit takes the n columns in use, one column per cycle, behind the
// registered read of the weight RAM. The last group of a row then keeps
// busy high while each column's sum is biased, saturated and looked up in
// the table RAM; the n results come on n consecutive cycles, each for one
// cycle only, and must be taken as they appear. The last result strobe
// coincides with the last busy cycle.
module int8_gemm_bias_sat_lut #(
    parameter int MAX_COLS  = 8,
    parameter int MAX_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    // Command interface
    input  logic                start,
    output logic                busy,
    input  igemm_pkg::op_t      op,
    input  logic [2:0]          column,
    input  logic [7:0]          position,
    input  logic signed [7:0]   byte_value,
    input  logic signed [31:0]  bias_value,
    input  logic signed [7:0]   act0,
    input  logic signed [7:0]   act1,
    input  logic signed [7:0]   act2,
    input  logic signed [7:0]   act3,
    input  logic                group_last,
    // Results
    output logic                result_valid,
    output logic [2:0]          out_column,
    output logic signed [7:0]   out_value,
    output logic                row_done,
    output logic                matrix_done,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import igemm_pkg::*;

    localparam int LIVE_COLS = (MAX_COLS < RESULT_CAP) ? MAX_COLS : RESULT_CAP;
    localparam int GROUPS    = (MAX_DEPTH + 3) / 4;
    localparam int GW        = $clog2(GROUPS + 1);
    localparam int WDEPTH    = LIVE_COLS * GROUPS;
    localparam int WAW       = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int CIW       = (LIVE_COLS > 1) ? $clog2(LIVE_COLS) : 1;
    localparam int CNW       = $clog2(LIVE_COLS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_EMIT
    } state_t;

    // Configuration registers
    logic [3:0]  cols_reg;
    logic [7:0]  depth_reg;
    logic [15:0] rows_reg;
    logic        cfg_wr;

    // Sequencer state
    state_t          state_reg,      state_next;
    logic [CNW-1:0]  col_cnt_reg,    col_cnt_next;
    logic [GW-1:0]   group_cnt_reg,  group_cnt_next;
    logic [15:0]     row_cnt_reg,    row_cnt_next;
    logic            last_reg,       last_next;
    logic            last_row_reg,   last_row_next;
    logic            va_reg,         va_next;
    logic            e1_valid_reg,   e1_valid_next;
    logic            result_valid_reg, result_valid_next;
    logic            row_done_reg,   row_done_next;
    logic            matrix_done_reg, matrix_done_next;
    logic [31:0]     acc_reg [LIVE_COLS];
    logic [31:0]     acc_next [LIVE_COLS];

    // Payload registers
    byte4_t          act_reg,        act_next;
    logic [3:0]      lane_en_reg,    lane_en_next;
    logic [CIW-1:0]  ca_reg,         ca_next;
    logic [CIW-1:0]  cb_reg;
    logic [CIW-1:0]  e1_col_reg,     e1_col_next;
    logic            e1_row_done_reg, e1_row_done_next;
    logic [7:0]      idx_reg,        idx_next;
    logic [2:0]      out_column_reg;
    logic [31:0]     bias_reg [LIVE_COLS];

    // Datapath signals
    logic            accept;
    logic            col_ok;
    logic            pos_ok;
    logic            wr_weight;
    logic [31:0]     w_waddr_full;
    logic [31:0]     w_raddr_full;
    byte4_t          wt_rd;
    mac_ctrl_t       mac_ctrl;
    mac_out_t        mac_res;
    logic [CNW-1:0]  n_cols;
    logic [15:0]     rows_eff;
    logic [CIW-1:0]  col_idx;
    logic            col_last;
    logic [CIW-1:0]  acc_ptr;
    logic [31:0]     acc_rd;
    logic [31:0]     bias_rd;
    logic signed [32:0] biased;
    logic [7:0]      sat8;
    logic [3:0]      lane_en_calc;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= COLS_RESET;
            depth_reg <= DEPTH_RESET;
            rows_reg  <= ROWS_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_COLS:  cols_reg  <= pwdata[3:0];
                REG_DEPTH: depth_reg <= pwdata[7:0];
                REG_ROWS:  rows_reg  <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            REG_COLS:  prdata = 32'(cols_reg);
            REG_DEPTH: prdata = 32'(depth_reg);
            REG_ROWS:  prdata = 32'(rows_reg);
            default:   prdata = '0;
        endcase
    end

    // Effective column and row counts.
    always_comb
    begin
        if (cols_reg == 4'd0)
        begin
            n_cols = CNW'(1);
        end
        else if (32'(cols_reg) > LIVE_COLS)
        begin
            n_cols = CNW'(LIVE_COLS);
        end
        else
        begin
            n_cols = CNW'(cols_reg);
        end
    end

    assign rows_eff = (rows_reg == 16'd0) ? 16'd1 : rows_reg;

    // ------------------------------------------------------------------
    // Weight RAMs: one per lane, one word per column and group
    // ------------------------------------------------------------------
    assign col_ok       = 32'(column) < LIVE_COLS;
    assign pos_ok       = 32'(position) < MAX_DEPTH;
    assign wr_weight    = accept && (op == OP_WEIGHT) && col_ok && pos_ok;
    assign w_waddr_full = 32'(column) * 32'(GROUPS) + 32'(position[7:2]);
    assign w_raddr_full = 32'(col_cnt_reg) * 32'(GROUPS) + 32'(group_cnt_reg);

    for (genvar gi = 0; gi < 4; gi++)
    begin : g_wram
        igemm_ram #(
            .WIDTH (8),
            .DEPTH (WDEPTH)
        ) u_wram (
            .clk   (clk),
            .we    (wr_weight && (position[1:0] == 2'(gi))),
            .waddr (w_waddr_full[WAW-1:0]),
            .wdata (byte_value),
            .raddr (w_raddr_full[WAW-1:0]),
            .rdata (wt_rd[gi])
        );
    end

    // Activation table RAM, read at the saturated sum plus offset.
    igemm_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_table (
        .clk   (clk),
        .we    (accept && (op == OP_TABLE)),
        .waddr (position),
        .wdata (byte_value),
        .raddr (idx_reg),
        .rdata (out_value)
    );

    // Bias words; written only by load words.
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_BIAS) && col_ok)
        begin
            bias_reg[column[CIW-1:0]] <= bias_value;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiply unit
    // ------------------------------------------------------------------
    assign mac_ctrl.valid   = va_reg;
    assign mac_ctrl.lane_en = lane_en_reg;

    igemm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .act    (act_reg),
        .wt     (wt_rd),
        .result (mac_res)
    );

    // Lanes whose depth lies inside the reduction length.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            lane_en_calc[r] = (((32'(group_cnt_reg) << 2) + 32'(r)) < 32'(depth_reg))
                && (((32'(group_cnt_reg) << 2) + 32'(r)) < MAX_DEPTH);
        end
    end

    // ------------------------------------------------------------------
    // Accumulator read, bias add and saturation
    // ------------------------------------------------------------------
    assign col_idx  = col_cnt_reg[CIW-1:0];
    assign col_last = (CNW'(col_cnt_reg + 1'b1) == n_cols);
    assign acc_ptr  = (state_reg == S_EMIT) ? col_idx : cb_reg;
    assign acc_rd   = acc_reg[acc_ptr];
    assign bias_rd  = bias_reg[col_idx];
    assign biased   = $signed({acc_rd[31], acc_rd}) + $signed({bias_rd[31], bias_rd});

    always_comb
    begin
        if (biased > SAT_MAX)
        begin
            sat8 = SAT_MAX[7:0];
        end
        else if (biased < SAT_MIN)
        begin
            sat8 = SAT_MIN[7:0];
        end
        else
        begin
            sat8 = biased[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        col_cnt_next      = col_cnt_reg;
        group_cnt_next    = group_cnt_reg;
        row_cnt_next      = row_cnt_reg;
        last_next         = last_reg;
        last_row_next     = last_row_reg;
        act_next          = act_reg;
        lane_en_next      = lane_en_reg;
        ca_next           = ca_reg;
        idx_next          = idx_reg;
        e1_col_next       = e1_col_reg;
        e1_row_done_next  = e1_row_done_reg;
        va_next           = 1'b0;
        e1_valid_next     = 1'b0;
        result_valid_next = e1_valid_reg;
        row_done_next     = e1_valid_reg && e1_row_done_reg;
        matrix_done_next  = e1_valid_reg && e1_row_done_reg && last_row_reg;
        acc_next          = acc_reg;

        // Products of the multiply unit go into their column.
        if (mac_res.valid)
        begin
            acc_next[cb_reg] = acc_rd + {{14{mac_res.sum[17]}}, mac_res.sum};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_ACT))
                begin
                    act_next     = {act3, act2, act1, act0};
                    lane_en_next = lane_en_calc;
                    last_next    = group_last;
                    col_cnt_next = '0;
                    state_next   = S_MAC;
                end
            end

            S_MAC:
            begin
                if (col_cnt_reg != n_cols)
                begin
                    // Issue the weight read for the next column.
                    va_next      = 1'b1;
                    ca_next      = col_idx;
                    col_cnt_next = CNW'(col_cnt_reg + 1'b1);
                end
                else if (!va_reg && !mac_res.valid)
                begin
                    if (last_reg)
                    begin
                        col_cnt_next  = '0;
                        last_row_next = (17'(row_cnt_reg) + 17'd1) >= 17'(rows_eff);
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        if (32'(group_cnt_reg) < GROUPS)
                        begin
                            group_cnt_next = GW'(group_cnt_reg + 1'b1);
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            S_EMIT:
            begin
                if (col_cnt_reg != n_cols)
                begin
                    // Saturated sum of this column addresses the table.
                    e1_valid_next    = 1'b1;
                    e1_col_next      = col_idx;
                    e1_row_done_next = col_last;
                    idx_next         = sat8 + TABLE_OFFSET;
                    col_cnt_next     = CNW'(col_cnt_reg + 1'b1);
                end
                else if (!e1_valid_reg)
                begin
                    for (int c = 0; c < LIVE_COLS; c++)
                    begin
                        acc_next[c] = '0;
                    end
                    group_cnt_next = '0;
                    row_cnt_next   = last_row_reg ? 16'd0 : 16'(row_cnt_reg + 1'b1);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters, accumulators and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            col_cnt_reg      <= '0;
            group_cnt_reg    <= '0;
            row_cnt_reg      <= '0;
            last_reg         <= 1'b0;
            last_row_reg     <= 1'b0;
            va_reg           <= 1'b0;
            e1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            row_done_reg     <= 1'b0;
            matrix_done_reg  <= 1'b0;
            for (int c = 0; c < LIVE_COLS; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            col_cnt_reg      <= col_cnt_next;
            group_cnt_reg    <= group_cnt_next;
            row_cnt_reg      <= row_cnt_next;
            last_reg         <= last_next;
            last_row_reg     <= last_row_next;
            va_reg           <= va_next;
            e1_valid_reg     <= e1_valid_next;
            result_valid_reg <= result_valid_next;
            row_done_reg     <= row_done_next;
            matrix_done_reg  <= matrix_done_next;
            acc_reg          <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        lane_en_reg     <= lane_en_next;
        ca_reg          <= ca_next;
        cb_reg          <= ca_reg;
        idx_reg         <= idx_next;
        e1_col_reg      <= e1_col_next;
        e1_row_done_reg <= e1_row_done_next;
        out_column_reg  <= 3'(e1_col_reg);
    end

    assign result_valid = result_valid_reg;
    assign out_column   = out_column_reg;
    assign row_done     = row_done_reg;
    assign matrix_done  = matrix_done_reg;

endmodule

>>> sv/igemm_checker.sv
// ============================================================================
// igemm_checker: port-level checks of the int8 dense layer
// Watches the command and result ports and flags results that appear out of
// turn or a sequencer that does not follow the accepted word.
// ============================================================================
module igemm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input igemm_pkg::op_t op,
    input logic           result_valid,
    input logic           row_done,
    input logic           matrix_done
);
    import igemm_pkg::*;

    // A result only follows a cycle in which the block was working.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
    else $error("result word without preceding work");

    // The end of a matrix is also the end of a row, and both mark a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        matrix_done |-> (row_done && result_valid))
    else $error("matrix or row end flag without result word");

    // The words of one row come on consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !row_done) |=> result_valid)
    else $error("gap inside the result words of a row");

    // An accepted activation group starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_ACT)) |=> busy)
    else $error("activation group did not start the sequencer");

    // A load word completes in its own cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_ACT)) |=> !busy)
    else $error("load word left the block busy");

endmodule

bind int8_gemm_bias_sat_lut igemm_checker u_checker (.*);
